@@ hw/rtl/mcmf_pkg.sv @@
// Shared types and constants for the 3x3 mean-centre median filter.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package mcmf_pkg;

  localparam int PIX_W             = 8;
  localparam int CFG_W             = 11;
  localparam int S_DATA_W          = 3 * PIX_W;
  localparam int APB_AW            = 3;
  localparam int APB_DW            = 32;
  localparam int MAX_LINE_DEFAULT  = 1024;
  localparam int MAX_LINES_DEFAULT = 1024;
  localparam int WIN_ROWS          = 3;
  localparam int WIN_N             = WIN_ROWS * WIN_ROWS;
  localparam int WIN_CENTER        = WIN_N / 2;

  typedef logic [PIX_W-1:0] pix_t;

  // Window element r*3+c holds row r (0 = oldest line) and column c (0 = leftmost).
  typedef pix_t [WIN_N-1:0] window_t;

  typedef struct packed {
    logic emit;
    logic last;
    logic border;
  } item_flags_t;

  // Register index, taken from paddr[2].
  typedef enum logic [0:0] {
    REG_LINE_LENGTH = 1'b0,
    REG_LINE_COUNT  = 1'b1
  } cfg_reg_t;

endpackage

`default_nettype wire

@@ hw/rtl/mcmf_ctrl.sv @@
// Register port and scan position tracking for the 3x3 mean-centre median filter.
// Decides per transfer whether it enters the pixel pipeline and whether it yields a result.
// Depends on mcmf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mcmf_ctrl #(
  parameter int MAX_LINE  = mcmf_pkg::MAX_LINE_DEFAULT,
  parameter int MAX_LINES = mcmf_pkg::MAX_LINES_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [mcmf_pkg::APB_AW-1:0]        paddr,
  input  logic [mcmf_pkg::APB_DW-1:0]        pwdata,
  output logic [mcmf_pkg::APB_DW-1:0]        prdata,
  output logic                               pready,
  input  logic                               accept,
  input  logic                               pad,
  output logic                               load,
  output logic [$clog2(MAX_LINE)-1:0]        col,
  output mcmf_pkg::item_flags_t              flags
);
  import mcmf_pkg::*;

  localparam int COL_W  = $clog2(MAX_LINE);
  localparam int ROW_W  = $clog2(MAX_LINES);
  localparam int LINE_W = $clog2(MAX_LINES + 2);
  localparam logic [CFG_W-1:0] LINE_LENGTH_RST = CFG_W'(640);
  localparam logic [CFG_W-1:0] LINE_COUNT_RST  = CFG_W'(480);

  logic [CFG_W-1:0]  line_length;
  logic [CFG_W-1:0]  line_count;
  logic [COL_W-1:0]  w_m1;
  logic [ROW_W-1:0]  h_m1;
  logic [COL_W-1:0]  in_position, in_position_next;
  logic [LINE_W-1:0] in_line, in_line_next;
  logic [COL_W-1:0]  out_x, out_x_next;
  logic [ROW_W-1:0]  out_y, out_y_next;
  logic              cfg_wr;
  cfg_reg_t          reg_idx;
  logic              in_image;
  logic              past_lag;
  logic              advance;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = cfg_reg_t'(paddr[2]);

  always_comb begin
    case (reg_idx)
      REG_LINE_LENGTH: prdata = APB_DW'(line_length);
      REG_LINE_COUNT:  prdata = APB_DW'(line_count);
      default:         prdata = '0;
    endcase
  end

  // Effective geometry minus one: zero counts as one, oversize is held at the maximum.
  always_comb begin
    if (line_length == '0) begin
      w_m1 = '0;
    end else if (32'(line_length) > 32'(MAX_LINE)) begin
      w_m1 = COL_W'(MAX_LINE - 1);
    end else begin
      w_m1 = COL_W'(line_length - CFG_W'(1));
    end
    if (line_count == '0) begin
      h_m1 = '0;
    end else if (32'(line_count) > 32'(MAX_LINES)) begin
      h_m1 = ROW_W'(MAX_LINES - 1);
    end else begin
      h_m1 = ROW_W'(line_count - CFG_W'(1));
    end
  end

  // Results start once one whole line plus one pixel has gone in.
  assign in_image = in_line <= LINE_W'(h_m1);
  assign past_lag = (in_line > LINE_W'(1)) || ((in_line == LINE_W'(1)) && (in_position != '0));
  assign advance  = !(in_image && pad);
  assign load     = accept && advance;
  assign col      = in_position;

  assign flags.emit   = advance && past_lag;
  assign flags.last   = (out_x == w_m1) && (out_y == h_m1);
  assign flags.border = (out_x == '0) || (out_y == '0) || (out_x == w_m1) || (out_y == h_m1);

  always_comb begin
    in_position_next = in_position;
    in_line_next     = in_line;
    out_x_next       = out_x;
    out_y_next       = out_y;
    if (cfg_wr) begin
      in_position_next = '0;
      in_line_next     = '0;
      out_x_next       = '0;
      out_y_next       = '0;
    end else if (load) begin
      if (in_position == w_m1) begin
        in_position_next = '0;
        in_line_next     = in_line + LINE_W'(1);
      end else begin
        in_position_next = in_position + COL_W'(1);
      end
      if (flags.emit) begin
        if (flags.last) begin
          in_position_next = '0;
          in_line_next     = '0;
          out_x_next       = '0;
          out_y_next       = '0;
        end else if (out_x == w_m1) begin
          out_x_next = '0;
          out_y_next = out_y + ROW_W'(1);
        end else begin
          out_x_next = out_x + COL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_length <= LINE_LENGTH_RST;
      line_count  <= LINE_COUNT_RST;
      in_position <= '0;
      in_line     <= '0;
      out_x       <= '0;
      out_y       <= '0;
    end else begin
      in_position <= in_position_next;
      in_line     <= in_line_next;
      out_x       <= out_x_next;
      out_y       <= out_y_next;
      if (cfg_wr) begin
        case (reg_idx)
          REG_LINE_LENGTH: line_length <= pwdata[CFG_W-1:0];
          REG_LINE_COUNT:  line_count  <= pwdata[CFG_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  a_restart_after_last: assert property (@(posedge clk) disable iff (rst)
    load && flags.emit && flags.last && !cfg_wr
      |=> in_position == '0 && in_line == '0 && out_x == '0 && out_y == '0)
    else $error("position counters not cleared after the final pixel");

  a_out_inside_image: assert property (@(posedge clk) disable iff (rst)
    out_x <= w_m1 && out_y <= h_m1)
    else $error("output position outside the image");

endmodule

`default_nettype wire

@@ hw/rtl/mcmf_window.sv @@
// Gray conversion, two line buffers and the 3x3 window registers.
// Stages: input register, line buffer read, window shift. Depends on mcmf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mcmf_window #(
  parameter int MAX_LINE = mcmf_pkg::MAX_LINE_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        load,
  output logic                        in_ready,
  input  mcmf_pkg::pix_t              red,
  input  mcmf_pkg::pix_t              green,
  input  mcmf_pkg::pix_t              blue,
  input  logic [$clog2(MAX_LINE)-1:0] col,
  input  mcmf_pkg::item_flags_t       flags,
  output logic                        win_valid,
  input  logic                        win_ready,
  output mcmf_pkg::window_t           win,
  output mcmf_pkg::item_flags_t       win_flags
);
  import mcmf_pkg::*;

  localparam int COL_W     = $clog2(MAX_LINE);
  localparam int RGB_SUM_W = PIX_W + 2;
  localparam int DIV3_PW   = 2 * RGB_SUM_W;
  localparam int DIV3_SH   = 11;
  localparam logic [RGB_SUM_W-1:0] DIV3_MUL = RGB_SUM_W'(683);

  // Stage A: input register.
  logic        a_valid;
  pix_t        a_red, a_green, a_blue;
  logic [COL_W-1:0] a_col;
  item_flags_t a_flags;
  logic [RGB_SUM_W-1:0] a_rgb_sum;
  logic [DIV3_PW-1:0]   a_prod;
  pix_t        a_gray;

  // Stage B: gray plus the same column of the two previous lines.
  logic        b_valid;
  pix_t        b_gray;
  logic [COL_W-1:0] b_col;
  item_flags_t b_flags;
  pix_t        lb1_rd, lb2_rd;

  // Stage C: window.
  logic        c_valid;
  item_flags_t c_flags;
  window_t     c_win;
  pix_t        new_col [WIN_ROWS];

  logic a_ready, a_fire, b_ready, b_fire, c_ready, c_done;

  pix_t lb1 [MAX_LINE];
  pix_t lb2 [MAX_LINE];

  // Division by three as a multiply by the rounded-up reciprocal; exact for sums below 2048.
  assign a_rgb_sum = RGB_SUM_W'(a_red) + RGB_SUM_W'(a_green) + RGB_SUM_W'(a_blue);
  assign a_prod    = DIV3_PW'(a_rgb_sum) * DIV3_PW'(DIV3_MUL);
  assign a_gray    = a_prod[DIV3_SH +: PIX_W];

  // The window stage drains an item that yields no result without waiting on the consumer.
  assign c_done   = c_valid && (!c_flags.emit || win_ready);
  assign c_ready  = !c_valid || c_done;
  assign b_fire   = b_valid && c_ready;
  assign b_ready  = !b_valid || c_ready;
  assign a_fire   = a_valid && b_ready;
  assign a_ready  = !a_valid || b_ready;
  assign in_ready = a_ready;

  assign win_valid = c_valid && c_flags.emit;
  assign win       = c_win;
  assign win_flags = c_flags;

  assign new_col[0] = lb2_rd;
  assign new_col[1] = lb1_rd;
  assign new_col[2] = b_gray;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid <= load;
      end
      if (b_ready) begin
        b_valid <= a_valid;
      end
      if (c_ready) begin
        c_valid <= b_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      a_red   <= red;
      a_green <= green;
      a_blue  <= blue;
      a_col   <= col;
      a_flags <= flags;
    end
    if (a_fire) begin
      b_gray  <= a_gray;
      b_col   <= a_col;
      b_flags <= a_flags;
    end
    if (b_fire) begin
      c_flags <= b_flags;
      for (int r = 0; r < WIN_ROWS; r++) begin
        c_win[r*WIN_ROWS]     <= c_win[r*WIN_ROWS + 1];
        c_win[r*WIN_ROWS + 1] <= c_win[r*WIN_ROWS + 2];
        c_win[r*WIN_ROWS + 2] <= new_col[r];
      end
    end
  end

  // Line buffers. The older line is written one stage late; a line of three or more
  // pixels always reads that entry well after the write.
  always_ff @(posedge clk) begin
    if (a_fire) begin
      lb1[a_col] <= a_gray;
      lb1_rd     <= lb1[a_col];
      lb2_rd     <= lb2[a_col];
    end
    if (b_fire) begin
      lb2[b_col] <= lb1_rd;
    end
  end

  a_window_holds: assert property (@(posedge clk) disable iff (rst)
    c_valid && c_flags.emit && !win_ready
      |=> c_valid && $stable(c_flags) && $stable(c_win[WIN_CENTER]))
    else $error("window moved while its result was stalled");

endmodule

`default_nettype wire

@@ hw/rtl/mcmf_median.sv @@
// Window sum, mean-centre replacement, median of nine and the result register.
// Stages: sum, mean, row sort, result. Depends on mcmf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mcmf_median (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  win_valid,
  output logic                  win_ready,
  input  mcmf_pkg::window_t     win,
  input  mcmf_pkg::item_flags_t win_flags,
  output logic                  out_valid,
  input  logic                  out_ready_in,
  output mcmf_pkg::pix_t        gray_out,
  output logic                  last
);
  import mcmf_pkg::*;

  localparam int SUM_W   = PIX_W + 4;
  localparam int DIV9_PW = 2 * SUM_W;
  localparam int DIV9_SH = 15;
  localparam logic [SUM_W-1:0] DIV9_MUL = SUM_W'(3641);

  function automatic pix_t min2(input pix_t a, input pix_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic pix_t max2(input pix_t a, input pix_t b);
    return (a < b) ? b : a;
  endfunction

  function automatic pix_t med3(input pix_t a, input pix_t b, input pix_t c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

  logic [SUM_W-1:0] win_sum;

  logic             d_valid;
  window_t          d_win;
  logic [SUM_W-1:0] d_sum;
  item_flags_t      d_flags;
  logic [DIV9_PW-1:0] d_prod;
  pix_t             d_mean;
  window_t          d_win_mc;

  logic             e_valid;
  window_t          e_win;
  pix_t             e_center;
  item_flags_t      e_flags;

  logic                      f_valid;
  pix_t [WIN_ROWS-1:0]       f_lo;
  pix_t [WIN_ROWS-1:0]       f_mid;
  pix_t [WIN_ROWS-1:0]       f_hi;
  pix_t                      f_center;
  item_flags_t               f_flags;
  pix_t                      f_median;

  logic d_ready, e_ready, f_ready, out_ready;

  always_comb begin
    win_sum = '0;
    for (int i = 0; i < WIN_N; i++) begin
      win_sum = win_sum + SUM_W'(win[i]);
    end
  end

  // Division by nine via reciprocal multiply; exact for every sum of nine pixels.
  assign d_prod = DIV9_PW'(d_sum) * DIV9_PW'(DIV9_MUL);
  assign d_mean = d_prod[DIV9_SH +: PIX_W];

  // The window with its centre replaced by the mean.
  always_comb begin
    d_win_mc             = d_win;
    d_win_mc[WIN_CENTER] = d_mean;
  end

  // With each row sorted, the median of nine is the median of the largest row minimum,
  // the middle row median and the smallest row maximum.
  assign f_median = med3(max2(max2(f_lo[0], f_lo[1]), f_lo[2]),
                         med3(f_mid[0], f_mid[1], f_mid[2]),
                         min2(min2(f_hi[0], f_hi[1]), f_hi[2]));

  assign out_ready = !out_valid || out_ready_in;
  assign f_ready   = !f_valid || out_ready;
  assign e_ready   = !e_valid || f_ready;
  assign d_ready   = !d_valid || e_ready;
  assign win_ready = d_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid   <= 1'b0;
      e_valid   <= 1'b0;
      f_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (d_ready) begin
        d_valid <= win_valid;
      end
      if (e_ready) begin
        e_valid <= d_valid;
      end
      if (f_ready) begin
        f_valid <= e_valid;
      end
      if (out_ready) begin
        out_valid <= f_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (win_valid && d_ready) begin
      d_win   <= win;
      d_sum   <= win_sum;
      d_flags <= win_flags;
    end
    if (d_valid && e_ready) begin
      e_win    <= d_win_mc;
      e_center <= d_win[WIN_CENTER];
      e_flags  <= d_flags;
    end
    if (e_valid && f_ready) begin
      for (int r = 0; r < WIN_ROWS; r++) begin
        f_lo[r]  <= min2(min2(e_win[r*WIN_ROWS], e_win[r*WIN_ROWS + 1]), e_win[r*WIN_ROWS + 2]);
        f_mid[r] <= med3(e_win[r*WIN_ROWS], e_win[r*WIN_ROWS + 1], e_win[r*WIN_ROWS + 2]);
        f_hi[r]  <= max2(max2(e_win[r*WIN_ROWS], e_win[r*WIN_ROWS + 1]), e_win[r*WIN_ROWS + 2]);
      end
      f_center <= e_center;
      f_flags  <= e_flags;
    end
    if (f_valid && out_ready) begin
      gray_out <= f_flags.border ? f_center : f_median;
      last     <= f_flags.last;
    end
  end

  a_sum_stage_holds: assert property (@(posedge clk) disable iff (rst)
    d_valid && !e_ready |=> d_valid && $stable(d_flags))
    else $error("sum stage overwritten while stalled");

endmodule

`default_nettype wire

@@ hw/rtl/mean_center_median_filter_3x3.sv @@
// Top level of the streaming 3x3 mean-centre median filter on gray from RGB pixels.
// Instantiates mcmf_ctrl, mcmf_window and mcmf_median; depends on mcmf_pkg.
//
//   Port group      Direction  Carries
//   s_t*            in         one RGB pixel or a drain item (pad) per transfer
//   m_t*            out        one gray result per transfer, tlast on the final pixel
//   p* (APB)        in/out     line_length at 0x0, line_count at 0x4
//
// One transfer per clock in and out while no stall holds the ready chain; a result is
// presented from the last of the seven register stages from input to result, the
// first of which loads at the edge of the transfer that completes its window.
// Output lags the input by one line plus one pixel; pad transfers drain the tail.
// Back-pressure on m_tready travels back through the stage ready chain, so empty
// stages still take input while a result waits. Reset clears control state only:
// the line buffers need no clearing pass, as every value that reaches a result comes
// from an entry written earlier in the same image.
`timescale 1ns / 1ps
`default_nettype none

module mean_center_median_filter_3x3 #(
  parameter int MAX_LINE  = mcmf_pkg::MAX_LINE_DEFAULT,
  parameter int MAX_LINES = mcmf_pkg::MAX_LINES_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [mcmf_pkg::S_DATA_W-1:0]   s_tdata,   // red [7:0], green [15:8], blue [23:16]
  input  logic                            s_tuser,   // pad [0]
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [mcmf_pkg::PIX_W-1:0]      m_tdata,   // gray_out [7:0]
  output logic                            m_tlast,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [mcmf_pkg::APB_AW-1:0]     paddr,
  input  logic [mcmf_pkg::APB_DW-1:0]     pwdata,
  output logic [mcmf_pkg::APB_DW-1:0]     prdata,
  output logic                            pready
);
  import mcmf_pkg::*;

  localparam int COL_W = $clog2(MAX_LINE);

  logic             accept;
  logic             load;
  logic [COL_W-1:0] col;
  item_flags_t      flags;
  logic             win_valid;
  logic             win_ready;
  window_t          win;
  item_flags_t      win_flags;

  assign accept = s_tvalid && s_tready;

  mcmf_ctrl #(
    .MAX_LINE  (MAX_LINE),
    .MAX_LINES (MAX_LINES)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .accept  (accept),
    .pad     (s_tuser),
    .load    (load),
    .col     (col),
    .flags   (flags)
  );

  mcmf_window #(
    .MAX_LINE (MAX_LINE)
  ) u_window (
    .clk       (clk),
    .rst       (rst),
    .load      (load),
    .in_ready  (s_tready),
    .red       (s_tdata[PIX_W-1:0]),
    .green     (s_tdata[2*PIX_W-1:PIX_W]),
    .blue      (s_tdata[3*PIX_W-1:2*PIX_W]),
    .col       (col),
    .flags     (flags),
    .win_valid (win_valid),
    .win_ready (win_ready),
    .win       (win),
    .win_flags (win_flags)
  );

  mcmf_median u_median (
    .clk          (clk),
    .rst          (rst),
    .win_valid    (win_valid),
    .win_ready    (win_ready),
    .win          (win),
    .win_flags    (win_flags),
    .out_valid    (m_tvalid),
    .out_ready_in (m_tready),
    .gray_out     (m_tdata),
    .last         (m_tlast)
  );

endmodule

`default_nettype wire
